// File: sv/afbt_pkg.sv
// Shared types, opcodes and flag positions for the ALU with flags and branch test
`timescale 1ns / 1ps

package afbt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int REQ_W          = 5;
    localparam int FLAG_W         = 4;

    localparam int FLAG_ZF = 0;
    localparam int FLAG_SF = 1;
    localparam int FLAG_CF = 2;
    localparam int FLAG_OF = 3;

    localparam logic [REQ_W-1:0] OP_ADD = 5'd0;
    localparam logic [REQ_W-1:0] OP_SUB = 5'd1;
    localparam logic [REQ_W-1:0] OP_MUL = 5'd2;
    localparam logic [REQ_W-1:0] OP_DIV = 5'd3;
    localparam logic [REQ_W-1:0] OP_INC = 5'd4;
    localparam logic [REQ_W-1:0] OP_DEC = 5'd5;
    localparam logic [REQ_W-1:0] OP_AND = 5'd6;
    localparam logic [REQ_W-1:0] OP_OR  = 5'd7;
    localparam logic [REQ_W-1:0] OP_XOR = 5'd8;
    localparam logic [REQ_W-1:0] OP_CMP = 5'd9;
    localparam logic [REQ_W-1:0] OP_JMP = 5'd10;
    localparam logic [REQ_W-1:0] OP_JZ  = 5'd11;
    localparam logic [REQ_W-1:0] OP_JNZ = 5'd12;
    localparam logic [REQ_W-1:0] OP_JG  = 5'd13;
    localparam logic [REQ_W-1:0] OP_JL  = 5'd14;
    localparam logic [REQ_W-1:0] OP_JGE = 5'd15;
    localparam logic [REQ_W-1:0] OP_JLE = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALU,
        ST_MUL,
        ST_MUL_END,
        ST_ABS_A,
        ST_ABS_B,
        ST_DIV,
        ST_SIGN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              status;
        logic [FLAG_W-1:0] flags;
        logic              branch_taken;
        logic              write_back;
    } t_res_info;

endpackage

// File: sv/afbt_seq_core.sv
// Sequencer and shared adder for arithmetic, multiply, divide and branch test
`timescale 1ns / 1ps

module afbt_seq_core #(
    parameter int DATA_WIDTH = afbt_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [afbt_pkg::REQ_W-1:0]   i_op,
    input  logic [DATA_WIDTH-1:0]        i_a,
    input  logic [DATA_WIDTH-1:0]        i_b,
    output logic                         o_ready,
    output logic                         o_done,
    input  logic                         i_take,
    output logic [DATA_WIDTH-1:0]        o_value,
    output afbt_pkg::t_res_info          o_info
);

    import afbt_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW);

    t_state            r_state, n_state;
    logic [REQ_W-1:0]  r_op, n_op;
    logic [DW-1:0]     r_a, n_a;
    logic [DW-1:0]     r_b, n_b;
    logic [DW-1:0]     r_hi, n_hi;
    logic [DW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_neg_q, n_neg_q;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic [DW-1:0]     r_value, n_value;
    t_res_info         r_info, n_info;

    logic [DW:0]       add_x, add_y, add_sum;
    logic              add_sub;
    logic              c_last;
    logic              c_qbit;
    logic [DW-1:0]     c_res;
    logic              c_zf, c_sf, c_of, c_ovf, c_taken;

    assign c_last  = (r_cnt == CW'(DW - 1));
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{DW{1'b0}}, add_sub};
    assign c_qbit  = ~add_sum[DW];
    assign c_ovf   = (r_hi != {DW{r_lo[DW-1]}});

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ST_ALU: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                add_sub = (r_op == OP_SUB) || (r_op == OP_DEC) || (r_op == OP_CMP);
            end
            ST_ABS_A: begin
                add_y   = {1'b0, r_a};
                add_sub = 1'b1;
            end
            ST_ABS_B: begin
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            ST_MUL: begin
                add_x   = {r_hi[DW-1], r_hi};
                add_y   = r_lo[0] ? {r_b[DW-1], r_b} : '0;
                add_sub = c_last;
            end
            ST_DIV: begin
                add_x   = {r_hi, r_lo[DW-1]};
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            ST_SIGN: begin
                add_y   = {1'b0, r_lo};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        c_taken = 1'b0;
        case (r_op)
            OP_JMP:  c_taken = 1'b1;
            OP_JZ:   c_taken = r_flags[FLAG_ZF];
            OP_JNZ:  c_taken = !r_flags[FLAG_ZF];
            OP_JG:   c_taken = !r_flags[FLAG_ZF] && (r_flags[FLAG_SF] == r_flags[FLAG_OF]);
            OP_JL:   c_taken = (r_flags[FLAG_SF] != r_flags[FLAG_OF]);
            OP_JGE:  c_taken = (r_flags[FLAG_SF] == r_flags[FLAG_OF]);
            OP_JLE:  c_taken = r_flags[FLAG_ZF] || (r_flags[FLAG_SF] != r_flags[FLAG_OF]);
            default: c_taken = 1'b0;
        endcase
    end

    always_comb begin
        c_res = add_sum[DW-1:0];
        case (r_op)
            OP_AND:  c_res = r_a & r_b;
            OP_OR:   c_res = r_a | r_b;
            OP_XOR:  c_res = r_a ^ r_b;
            default: c_res = add_sum[DW-1:0];
        endcase
    end

    assign c_zf = (c_res == '0);
    assign c_sf = c_res[DW-1];
    assign c_of = add_sub ? ((r_a[DW-1] != r_b[DW-1]) && (c_res[DW-1] != r_a[DW-1]))
                          : ((r_a[DW-1] == r_b[DW-1]) && (c_res[DW-1] != r_a[DW-1]));

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        n_neg_q = r_neg_q;
        n_flags = r_flags;
        n_value = r_value;
        n_info  = r_info;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_a     = i_a;
                    n_b     = ((i_op == OP_INC) || (i_op == OP_DEC)) ? DW'(1) : i_b;
                    n_neg_q = i_a[DW-1] ^ i_b[DW-1];
                    n_hi    = '0;
                    n_lo    = i_a;
                    n_cnt   = '0;
                    case (i_op)
                        OP_MUL: n_state = ST_MUL;
                        OP_DIV: begin
                            if (i_b == '0) begin
                                n_value = '0;
                                n_info  = '{status: 1'b1, flags: r_flags,
                                            branch_taken: 1'b0, write_back: 1'b0};
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_ABS_A;
                            end
                        end
                        default: n_state = ST_ALU;
                    endcase
                end
            end
            ST_ALU: begin
                n_state = ST_DONE;
                case (r_op)
                    OP_ADD, OP_INC, OP_SUB, OP_DEC: begin
                        n_value = c_res;
                        n_info  = '{status: 1'b0, flags: {c_of, add_sum[DW], c_sf, c_zf},
                                    branch_taken: 1'b0, write_back: 1'b1};
                    end
                    OP_CMP: begin
                        n_value = '0;
                        n_info  = '{status: 1'b0, flags: {c_of, add_sum[DW], c_sf, c_zf},
                                    branch_taken: 1'b0, write_back: 1'b0};
                    end
                    OP_AND, OP_OR, OP_XOR: begin
                        n_value = c_res;
                        n_info  = '{status: 1'b0, flags: {2'b00, c_sf, c_zf},
                                    branch_taken: 1'b0, write_back: 1'b1};
                    end
                    default: begin
                        n_value = '0;
                        n_info  = '{status: 1'b0, flags: r_flags,
                                    branch_taken: c_taken, write_back: 1'b0};
                    end
                endcase
            end
            ST_MUL: begin
                n_hi  = add_sum[DW:1];
                n_lo  = {add_sum[0], r_lo[DW-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (c_last) begin
                    n_state = ST_MUL_END;
                end
            end
            ST_MUL_END: begin
                n_value = r_lo;
                n_info  = '{status: 1'b0,
                            flags: {c_ovf, c_ovf, r_lo[DW-1], (r_lo == '0)},
                            branch_taken: 1'b0, write_back: 1'b1};
                n_state = ST_DONE;
            end
            ST_ABS_A: begin
                if (r_a[DW-1]) begin
                    n_lo = add_sum[DW-1:0];
                end
                n_state = ST_ABS_B;
            end
            ST_ABS_B: begin
                if (r_b[DW-1]) begin
                    n_b = add_sum[DW-1:0];
                end
                n_hi    = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_hi  = c_qbit ? add_sum[DW-1:0] : add_x[DW-1:0];
                n_lo  = {r_lo[DW-2:0], c_qbit};
                n_cnt = r_cnt + CW'(1);
                if (c_last) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                n_value = r_neg_q ? add_sum[DW-1:0] : r_lo;
                n_info  = '{status: 1'b0,
                            flags: {2'b00, n_value[DW-1], (n_value == '0)},
                            branch_taken: 1'b0, write_back: 1'b1};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_flags = r_info.flags;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        r_neg_q <= n_neg_q;
        r_value <= n_value;
        r_info  <= n_info;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_done  = (r_state == ST_DONE);
    assign o_value = r_value;
    assign o_info  = r_info;

    a_div_zero_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_info.status) |-> (r_info.flags == r_flags && !r_info.write_back))
        else $error("divide by zero altered flags or wrote back");

    a_branch_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_info.branch_taken) |->
            (!r_info.write_back && r_info.flags == r_flags))
        else $error("branch result wrote back or altered flags");

    a_take_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_take) |=> (r_state == ST_IDLE && r_flags == $past(r_info.flags)))
        else $error("flag register not updated on result hand-off");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !c_last) |=> (r_state == ST_DIV && r_cnt == $past(r_cnt) + CW'(1)))
        else $error("divide step counter slipped");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && c_last) |=> (r_state == ST_MUL_END))
        else $error("multiply did not finish after its last step");

endmodule

// File: sv/alu_with_flags_and_branch_test_unit.sv
// Top level: stream ports, output register and the iterative ALU core
//
//  channel  | dir | beat contents (lowest bits first)
//  s_axis   | in  | tdata: operand_a, operand_b; tuser: req_type
//  m_axis   | out | tdata: result_value, write_back, branch_taken, flags_out, status
//
//  Logic, add, sub, inc, dec, cmp and jumps: one ALU state, then the done state and the output register.
//  Mul: one shift-add step a cycle through the shared adder.
//  Div: two magnitude steps, one restoring step a cycle and a sign fix-up; divide by
//  zero goes straight to the done state. A new beat is taken once the core is idle.
//  Reset clears the flag register, the sequencer and the output valid.
//  A stalled output holds the core in its done state; the flags update on hand-off.
`timescale 1ns / 1ps

module alu_with_flags_and_branch_test_unit #(
    parameter int DATA_WIDTH = afbt_pkg::DATA_WIDTH_DEF,
    localparam int IN_W      = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + 7 + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_W-1:0]            s_axis_tdata,  // operand_a, operand_b
    input  logic [afbt_pkg::REQ_W-1:0] s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata   // result_value, write_back,
                                                      // branch_taken, flags_out, status
);

    import afbt_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic            core_ready;
    logic            core_done;
    logic            core_take;
    logic [DW-1:0]   core_value;
    t_res_info       core_info;

    logic            r_out_valid;
    logic [DW-1:0]   r_out_value;
    t_res_info       r_out_info;

    assign core_take = core_done && (!r_out_valid || m_axis_tready);

    afbt_seq_core #(
        .DATA_WIDTH (DW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid && core_ready),
        .i_op    (s_axis_tuser),
        .i_a     (s_axis_tdata[DW-1:0]),
        .i_b     (s_axis_tdata[2*DW-1:DW]),
        .o_ready (core_ready),
        .o_done  (core_done),
        .i_take  (core_take),
        .o_value (core_value),
        .o_info  (core_info)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_take) begin
            r_out_value <= core_value;
            r_out_info  <= core_info;
        end
    end

    assign s_axis_tready = core_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_info.status, r_out_info.flags,
                                   r_out_info.branch_taken, r_out_info.write_back,
                                   r_out_value});

endmodule
